// ===== src/tmcp_pkg.sv =====
// Shared constants and types for the trellis min-cost path block.
`default_nettype none

package tmcp_pkg;

  // default sizes of the trellis
  localparam int unsigned DefMaxNodes   = 64;
  localparam int unsigned DefMaxColumns = 64;
  localparam int unsigned DefCostWidth  = 32;

  // fixed widths of the cost ports, Q16.16
  localparam int unsigned InCostW  = 32;
  localparam int unsigned OutCostW = 32;

  // markers that travel with one pair word
  typedef struct packed {
    logic last_prev;
    logic last_in_column;
    logic final_column;
  } flags_t;

endpackage

`default_nettype wire

// ===== src/tmcp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tmcp_ram
  import tmcp_pkg::*;
#(
  parameter int unsigned WIDTH = DefCostWidth,
  parameter int unsigned DEPTH = DefMaxNodes
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/trellis_min_cost_path.sv =====
// Top level: min-sum Viterbi trellis; traces the cheapest path to final node 0.
//
// Usage: drive one pair word (prev_node_i, cur_node_i, transition_cost_i,
// node_cost_i and the three markers) and raise start; the word is taken at a
// rising edge with start high and busy low. Pairs of one current node come
// back to back, the last one marked by last_prev_i.
// Pair pipeline: cost RAM read, add, compare, node-cost add and write back;
// one pair per cycle while busy is low. A pair that closes a column holds
// busy high until its cost and predecessor are written and the cost banks
// swap (the two banks of the cost RAM serve as previous and current
// column).
// Traceback: the pair that closes the final column starts a walk through the
// predecessor RAM from node zero, one column per cycle, limited by its
// registered read. The results are registered, one per cycle, final column
// first, last_o on column zero. busy stays high until the walk ends. Each
// result is on the outputs for one cycle with valid_o; the receiver cannot
// stall.
// Reset: asynchronous, active low; the trellis restarts at column one with
// every predecessor at cost zero. Same state follows every traceback. The RAMs
// are not cleared.
`default_nettype none

module trellis_min_cost_path
  import tmcp_pkg::*;
#(
  parameter int unsigned MAX_NODES   = DefMaxNodes,
  parameter int unsigned MAX_COLUMNS = DefMaxColumns,
  parameter int unsigned COST_WIDTH  = DefCostWidth,
  localparam int unsigned NodeW      = $clog2(MAX_NODES),
  localparam int unsigned ColW       = $clog2(MAX_COLUMNS)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [NodeW-1:0]    prev_node_i,
  input  wire logic [NodeW-1:0]    cur_node_i,
  input  wire logic [InCostW-1:0]  transition_cost_i,
  input  wire logic [InCostW-1:0]  node_cost_i,
  input  wire logic                last_prev_i,
  input  wire logic                last_in_column_i,
  input  wire logic                final_column_i,
  output logic                     valid_o,
  output logic [ColW-1:0]          column_o,
  output logic [NodeW-1:0]         chosen_node_o,
  output logic [OutCostW-1:0]      total_cost_o,
  output logic                     last_o
);

  localparam logic [63:0] CostTop64 = (64'd1 << COST_WIDTH) - 64'd1;
  localparam logic [63:0] OutTop64  = (64'd1 << OutCostW) - 64'd1;
  localparam int unsigned CostAw    = NodeW + 1;
  localparam int unsigned PredAw    = ColW + NodeW;

  typedef enum logic {StIdle, StTrace} state_e;

  // clamp an input cost into the internal cost width
  function automatic logic [COST_WIDTH-1:0] clamp_in(input logic [InCostW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > CostTop64) ? '1 : w[COST_WIDTH-1:0];
  endfunction

  // clamp an internal cost onto the output width
  function automatic logic [OutCostW-1:0] clamp_out(input logic [COST_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > OutTop64) ? '1 : w[OutCostW-1:0];
  endfunction

  // saturating add
  function automatic logic [COST_WIDTH-1:0] sat_add(input logic [COST_WIDTH-1:0] a,
                                                    input logic [COST_WIDTH-1:0] b);
    logic [COST_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_WIDTH] ? '1 : s[COST_WIDTH-1:0];
  endfunction

  // node index reduced into the node range
  function automatic logic [NodeW-1:0] wrap_node(input logic [NodeW-1:0] n);
    logic [NodeW:0] e;
    e = {1'b0, n};
    return (e >= (NodeW+1)'(MAX_NODES)) ? NodeW'(e - (NodeW+1)'(MAX_NODES)) : n;
  endfunction

  // control state
  state_e            state_q;
  logic              bank_q;       // bank of the column being built
  logic              first_q;      // building column one: predecessor cost is zero
  logic [ColW-1:0]   col_q;
  logic [ColW-1:0]   tb_col_q;
  logic              tb_first_q;
  logic [OutCostW-1:0] tb_total_q;

  // pipeline stages
  logic              s1_v_q, s2_v_q, s3_v_q;
  flags_t            s1_f_q, s2_f_q, s3_f_q;
  logic [NodeW-1:0]  s1_pn_q, s1_cn_q, s2_pn_q, s2_cn_q, s3_cn_q, s3_pred_q;
  logic [COST_WIDTH-1:0] s1_tc_q, s1_nc_q, s2_nc_q, s3_nc_q;
  logic [COST_WIDTH-1:0] s2_cost_q, s3_win_q;
  logic              s1_zero_q;

  // running best for the current node
  logic [COST_WIDTH-1:0] best_cost_q;
  logic              best_valid_q;
  logic [NodeW-1:0]  best_pred_q;
  logic [COST_WIDTH-1:0] node0_cost_q;

  logic              accept;
  logic [COST_WIDTH-1:0] cost_rdata;
  logic [NodeW-1:0]  pred_rdata;
  logic [COST_WIDTH-1:0] prev_cost;
  logic              upd;
  logic [COST_WIDTH-1:0] win_cost;
  logic [NodeW-1:0]  win_pred;
  logic [COST_WIDTH-1:0] node_sum;
  logic              s3_we;
  logic [NodeW-1:0]  tb_node;
  logic              tb_re;

  // hold off during traceback and while a column-closing word is in flight
  assign busy = (state_q == StTrace)
              || (s1_v_q && s1_f_q.last_prev && s1_f_q.last_in_column)
              || (s2_v_q && s2_f_q.last_prev && s2_f_q.last_in_column)
              || (s3_v_q && s3_f_q.last_prev && s3_f_q.last_in_column);
  assign accept = start && !busy;

  // cost RAM: two banks, previous column and current column
  tmcp_ram #(
    .WIDTH (COST_WIDTH),
    .DEPTH (1 << CostAw)
  ) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (s3_we),
    .waddr_i ({bank_q, s3_cn_q}),
    .wdata_i (node_sum),
    .re_i    (accept),
    .raddr_i ({~bank_q, wrap_node(prev_node_i)}),
    .rdata_o (cost_rdata)
  );

  // predecessor RAM, one row per column
  tmcp_ram #(
    .WIDTH (NodeW),
    .DEPTH (1 << PredAw)
  ) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (s3_we),
    .waddr_i ({col_q, s3_cn_q}),
    .wdata_i (s3_pred_q),
    .re_i    (tb_re),
    .raddr_i ({tb_col_q, tb_node}),
    .rdata_o (pred_rdata)
  );

  // stage 1 add, stage 2 compare, stage 3 node-cost add
  always_comb begin
    prev_cost = s1_zero_q ? '0 : cost_rdata;
    upd       = !best_valid_q || (s2_cost_q < best_cost_q);
    win_cost  = upd ? s2_cost_q : best_cost_q;
    win_pred  = upd ? s2_pn_q : best_pred_q;
    node_sum  = sat_add(s3_win_q, s3_nc_q);
    s3_we     = s3_v_q;
  end

  // pipeline valids and best tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      s1_f_q       <= '0;
      s2_f_q       <= '0;
      s3_f_q       <= '0;
      best_valid_q <= 1'b0;
      best_cost_q  <= '0;
      best_pred_q  <= '0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && s2_f_q.last_prev;
      if (accept) begin
        s1_f_q <= '{last_prev: last_prev_i, last_in_column: last_in_column_i,
                    final_column: final_column_i};
      end
      if (s1_v_q) begin
        s2_f_q <= s1_f_q;
      end
      if (s2_v_q) begin
        s3_f_q <= s2_f_q;
        if (s2_f_q.last_prev) begin
          best_valid_q <= 1'b0;
          best_cost_q  <= '0;
          best_pred_q  <= '0;
        end else if (upd) begin
          best_valid_q <= 1'b1;
          best_cost_q  <= s2_cost_q;
          best_pred_q  <= s2_pn_q;
        end
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pn_q   <= wrap_node(prev_node_i);
      s1_cn_q   <= wrap_node(cur_node_i);
      s1_tc_q   <= clamp_in(transition_cost_i);
      s1_nc_q   <= clamp_in(node_cost_i);
      s1_zero_q <= first_q;
    end
    if (s1_v_q) begin
      s2_pn_q   <= s1_pn_q;
      s2_cn_q   <= s1_cn_q;
      s2_nc_q   <= s1_nc_q;
      s2_cost_q <= sat_add(prev_cost, s1_tc_q);
    end
    if (s2_v_q && s2_f_q.last_prev) begin
      s3_cn_q   <= s2_cn_q;
      s3_nc_q   <= s2_nc_q;
      s3_win_q  <= win_cost;
      s3_pred_q <= win_pred;
    end
    if (s3_we && (s3_cn_q == '0)) begin
      node0_cost_q <= node_sum;
    end
  end

  // traceback read address
  always_comb begin
    tb_node = tb_first_q ? '0 : pred_rdata;
    tb_re   = (state_q == StTrace);
  end

  // column bookkeeping, traceback sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      bank_q        <= 1'b0;
      first_q       <= 1'b1;
      col_q         <= ColW'(1);
      tb_col_q      <= '0;
      tb_first_q    <= 1'b1;
      tb_total_q    <= '0;
      valid_o       <= 1'b0;
      column_o      <= '0;
      chosen_node_o <= '0;
      total_cost_o  <= '0;
      last_o        <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: begin
          valid_o <= 1'b0;
          if (s3_v_q && s3_f_q.last_in_column) begin
            if (s3_f_q.final_column) begin
              state_q    <= StTrace;
              tb_col_q   <= col_q;
              tb_first_q <= 1'b1;
              tb_total_q <= clamp_out((s3_cn_q == '0) ? node_sum : node0_cost_q);
              col_q      <= ColW'(1);
              first_q    <= 1'b1;
            end else begin
              bank_q  <= ~bank_q;
              first_q <= 1'b0;
              if (col_q < ColW'(MAX_COLUMNS - 1)) begin
                col_q <= col_q + ColW'(1);
              end
            end
          end
        end
        StTrace: begin
          valid_o       <= 1'b1;
          column_o      <= tb_col_q;
          chosen_node_o <= tb_node;
          total_cost_o  <= tb_total_q;
          last_o        <= (tb_col_q == '0);
          tb_first_q    <= 1'b0;
          if (tb_col_q == '0) begin
            state_q <= StIdle;
          end else begin
            tb_col_q <= tb_col_q - ColW'(1);
          end
        end
        default: begin
          valid_o <= 1'b0;
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
